### hw/rtl/dpod_pkg.sv
// Shared types and constants for the dual piezo onset detector.
package dpod_pkg;

  // Fixed field widths.
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TATUM_W   = 16;
  localparam int unsigned LEVEL_W   = 10;
  localparam int unsigned REFR_W    = 16;
  localparam int unsigned SLOT_OUT_W = 5;
  // Two bars of 24 tatums of up to 65535 ms fit in 21 bits.
  localparam int unsigned WINDOW_W  = 21;

  // Tatums in a two-bar window for straight and swing time.
  localparam logic [4:0] TATUMS_STRAIGHT = 5'd24;
  localparam logic [4:0] TATUMS_SWING    = 5'd16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SWING_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_KICK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_SNARE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_KICK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_SNARE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_KICK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_SNARE = 3'd6;

  // Register values after reset.
  localparam logic [LEVEL_W-1:0] RST_DISCHARGE  = 10'd6;
  localparam logic [LEVEL_W-1:0] RST_DELTA_KICK = 10'd70;
  localparam logic [LEVEL_W-1:0] RST_DELTA_SNARE = 10'd50;
  localparam logic [REFR_W-1:0]  RST_REFRACTORY = 16'd50;

  typedef struct packed {
    logic                swing_mode;
    logic [LEVEL_W-1:0]  discharge_kick;
    logic [LEVEL_W-1:0]  discharge_snare;
    logic [LEVEL_W-1:0]  delta_kick;
    logic [LEVEL_W-1:0]  delta_snare;
    logic [REFR_W-1:0]   refractory_kick;
    logic [REFR_W-1:0]   refractory_snare;
  } cfg_t;

  // One item as it travels from the front end to the back end.
  typedef struct packed {
    logic [TIME_W-1:0]   now_ms;
    logic [WINDOW_W-1:0] window;
    logic [LEVEL_W-1:0]  level_kick;
    logic [LEVEL_W-1:0]  level_snare;
  } item_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_ENV,
    BK_DECIDE
  } back_state_t;

endpackage

### hw/rtl/dpod_ram.sv
// Generic single-port-write, registered-read RAM.
module dpod_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/dpod_front.sv
// Front end: accepts items and works out the two-bar pruning window.
module dpod_front (
  input  dpod_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dpod_pkg::TIME_W-1:0]          in_now_ms,
  input  logic [dpod_pkg::TATUM_W-1:0]         in_tatum_period,
  input  logic [dpod_pkg::LEVEL_W-1:0]         in_level_kick,
  input  logic [dpod_pkg::LEVEL_W-1:0]         in_level_snare,
  input  logic                                 q_full,
  output logic                                 q_push,
  output dpod_pkg::item_t                      q_item
);
  import dpod_pkg::*;

  logic [4:0] tatums;

  // The window is 16 tatums in swing mode and 24 otherwise.
  assign tatums = cfg.swing_mode ? TATUMS_SWING : TATUMS_STRAIGHT;

  always_comb begin
    q_item.now_ms      = in_now_ms;
    q_item.window      = WINDOW_W'(in_tatum_period) * WINDOW_W'(tatums);
    q_item.level_kick  = in_level_kick;
    q_item.level_snare = in_level_snare;
  end

  // A transfer happens whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

### hw/rtl/dpod_queue.sv
// Two-entry queue between the front end and the back end.
module dpod_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dpod_pkg::item_t       push_item,
  output logic                  full,
  input  logic                  pop,
  output dpod_pkg::queue_head_t head
);
  import dpod_pkg::*;

  item_t      entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full   = (count_r == 2'd2);
  assign do_pop = pop && (count_r != 2'd0);

  // Pointer and occupancy bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = entry_r[rd_ptr_r];

endmodule

### hw/rtl/dpod_back.sv
// Back end: prunes the onset ring, runs the envelopes and decides onsets.
module dpod_back #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dpod_pkg::cfg_t                      cfg,
  input  dpod_pkg::queue_head_t               head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_onset_found,
  output logic                                out_onset_is_snare,
  output logic [dpod_pkg::SLOT_OUT_W-1:0]     out_newest_slot,
  output logic [dpod_pkg::SLOT_OUT_W-1:0]     out_oldest_slot
);
  import dpod_pkg::*;

  localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] ready_time(input logic [TIME_W-1:0] now,
                                                   input logic [REFR_W-1:0] gap);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + (TIME_W+1)'(gap);
    ready_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  back_state_t state_r, state_nxt;
  item_t       item_r;

  // Ring pointers and per-slot valid bits.
  logic [SLOT_W-1:0]        oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]        write_r, write_nxt;
  logic [SLOT_W-1:0]        recent_r, recent_nxt;
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic                     ent_valid_r;
  logic [TIME_W-1:0]        rd_data;
  logic [TIME_W-1:0]        entry;
  logic                     is_old;
  logic                     advance;

  // Envelope and timing state.
  logic [LEVEL_W-1:0] env_kick_r, env_kick_nxt;
  logic [LEVEL_W-1:0] env_snare_r, env_snare_nxt;
  logic [LEVEL_W-1:0] lat_kick_r, lat_kick_nxt;
  logic [LEVEL_W-1:0] lat_snare_r, lat_snare_nxt;
  logic [TIME_W-1:0]  last_tick_r, last_tick_nxt;
  logic [TIME_W-1:0]  kick_ready_r, kick_ready_nxt;
  logic [TIME_W-1:0]  snare_ready_r, snare_ready_nxt;

  logic [LEVEL_W-1:0] peak_kick, peak_snare;
  logic [LEVEL_W-1:0] dis_kick, dis_snare;
  logic               tick;
  logic               kick_hit, snare_hit, rec;
  logic               fire;
  logic               env_load;
  logic               check_en;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_snare_r;
  logic [SLOT_OUT_W-1:0] out_newest_r, out_oldest_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (!advance) begin
          state_nxt = BK_ENV;
        end
      end
      BK_ENV: begin
        state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (fire) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State decoded into control.
  always_comb begin
    q_pop    = 1'b0;
    check_en = 1'b0;
    env_load = 1'b0;
    fire     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop = head.valid;
      end
      BK_CHECK: begin
        check_en = 1'b1;
      end
      BK_ENV: begin
        env_load = 1'b1;
      end
      BK_DECIDE: begin
        fire = !out_valid_r || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Pruning: one ring entry is checked per cycle; the read address follows
  // the pointer value of the next cycle so each check sees its own entry.
  assign entry   = ent_valid_r ? rd_data : '0;
  assign is_old  = (({1'b0, entry} + (TIME_W+1)'(item_r.window)) < {1'b0, item_r.now_ms});
  assign advance = check_en && is_old && (oldest_r != write_r);
  assign oldest_nxt = advance ? next_slot(oldest_r) : oldest_r;

  dpod_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (fire && rec),
    .wr_addr (write_r),
    .wr_data (item_r.now_ms),
    .rd_addr (oldest_nxt),
    .rd_data (rd_data)
  );

  // Peak hold, then once per new millisecond discharge and latch.
  always_comb begin
    peak_kick  = (item_r.level_kick > env_kick_r) ? item_r.level_kick : env_kick_r;
    peak_snare = (item_r.level_snare > env_snare_r) ? item_r.level_snare : env_snare_r;
    dis_kick   = (peak_kick > cfg.discharge_kick) ? peak_kick - cfg.discharge_kick : '0;
    dis_snare  = (peak_snare > cfg.discharge_snare) ? peak_snare - cfg.discharge_snare : '0;
    tick       = item_r.now_ms > last_tick_r;

    env_kick_nxt  = env_kick_r;
    env_snare_nxt = env_snare_r;
    lat_kick_nxt  = lat_kick_r;
    lat_snare_nxt = lat_snare_r;
    last_tick_nxt = last_tick_r;
    if (env_load) begin
      env_kick_nxt  = tick ? dis_kick : peak_kick;
      env_snare_nxt = tick ? dis_snare : peak_snare;
      if (tick) begin
        lat_kick_nxt  = dis_kick;
        lat_snare_nxt = dis_snare;
        last_tick_nxt = item_r.now_ms;
      end
    end
  end

  // Onset decision; the kick channel is checked first and wins.
  always_comb begin
    kick_hit  = ({1'b0, env_kick_r} > ({1'b0, lat_kick_r} + {1'b0, cfg.delta_kick})) &&
                (item_r.now_ms > kick_ready_r);
    snare_hit = !kick_hit &&
                ({1'b0, env_snare_r} > ({1'b0, lat_snare_r} + {1'b0, cfg.delta_snare})) &&
                (item_r.now_ms > snare_ready_r);
    rec       = kick_hit || snare_hit;

    kick_ready_nxt  = kick_ready_r;
    snare_ready_nxt = snare_ready_r;
    write_nxt       = write_r;
    recent_nxt      = recent_r;
    if (fire && kick_hit) begin
      kick_ready_nxt = ready_time(item_r.now_ms, cfg.refractory_kick);
    end
    if (fire && snare_hit) begin
      snare_ready_nxt = ready_time(item_r.now_ms, cfg.refractory_snare);
    end
    if (fire && rec) begin
      recent_nxt = write_r;
      write_nxt  = next_slot(write_r);
    end
  end

  // The result stays until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      oldest_r      <= '0;
      write_r       <= '0;
      recent_r      <= '0;
      valid_r       <= '0;
      ent_valid_r   <= 1'b0;
      env_kick_r    <= '0;
      env_snare_r   <= '0;
      lat_kick_r    <= '0;
      lat_snare_r   <= '0;
      last_tick_r   <= '0;
      kick_ready_r  <= '0;
      snare_ready_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      oldest_r      <= oldest_nxt;
      write_r       <= write_nxt;
      recent_r      <= recent_nxt;
      ent_valid_r   <= valid_r[oldest_nxt];
      if (fire && rec) begin
        valid_r[write_r] <= 1'b1;
      end
      env_kick_r    <= env_kick_nxt;
      env_snare_r   <= env_snare_nxt;
      lat_kick_r    <= lat_kick_nxt;
      lat_snare_r   <= lat_snare_nxt;
      last_tick_r   <= last_tick_nxt;
      kick_ready_r  <= kick_ready_nxt;
      snare_ready_r <= snare_ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= head.item;
    end
    if (fire) begin
      out_found_r  <= rec;
      out_snare_r  <= snare_hit;
      out_newest_r <= SLOT_OUT_W'(recent_nxt);
      out_oldest_r <= SLOT_OUT_W'(oldest_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_onset_found    = out_found_r;
  assign out_onset_is_snare = out_snare_r;
  assign out_newest_slot    = out_newest_r;
  assign out_oldest_slot    = out_oldest_r;

  // The oldest pointer only moves while the ring is being pruned.
  a_oldest_moves_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_CHECK) |=> $stable(oldest_r))
    else $error("oldest pointer moved outside the pruning state");

  // Pruning never walks past the write slot.
  a_prune_stops_at_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHECK && oldest_r == write_r) |=> (state_r == BK_ENV))
    else $error("pruning continued past the write slot");

  // A new result only appears after the decision state.
  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == BK_DECIDE))
    else $error("result raised outside the decision state");

  // A snare flag without an onset would be a decode slip.
  a_snare_needs_onset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_snare_r) |-> out_found_r)
    else $error("snare flagged without an onset");

endmodule

### hw/rtl/dual_piezo_onset_detector_top.sv
// Top level of the dual piezo onset detector.
//
// Each input transfer carries a millisecond timestamp, the tatum period and
// one sample from the kick and snare piezo sensors. For every input transfer
// exactly one result transfer follows, in order: an onset flag, a snare flag,
// the ring slot of the newest recorded onset and that of the oldest onset
// still inside the two-bar window. Configuration is written through cfg_we,
// cfg_index and cfg_wdata and takes effect at once; the user must write it
// only while idle, which the block itself does not enforce.
// A two-entry queue sits between the front end and the back end. For each
// item the back end steps through its idle, check, envelope and decide
// states, staying in the check state while it prunes ring entries, the
// pruning walk reading one entry per cycle from the onset ring memory. The
// result is held in an output register, so the back end carries one more
// item up to its decision while the receiver stalls; then the queue fills
// and in_ready falls. Reset clears the envelopes, timers, ring pointers and
// ring valid bits at once and restores the configuration defaults; no
// clearing pass.
module dual_piezo_onset_detector_top #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpod_pkg::TIME_W-1:0]         in_now_ms,
  input  logic [dpod_pkg::TATUM_W-1:0]        in_tatum_period,
  input  logic [dpod_pkg::LEVEL_W-1:0]        in_level_kick,
  input  logic [dpod_pkg::LEVEL_W-1:0]        in_level_snare,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_onset_found,
  output logic                                out_onset_is_snare,
  output logic [dpod_pkg::SLOT_OUT_W-1:0]     out_newest_slot,
  output logic [dpod_pkg::SLOT_OUT_W-1:0]     out_oldest_slot,
  input  logic                                cfg_we,
  input  logic [dpod_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dpod_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        q_full;
  logic        q_push;
  item_t       q_item;
  logic        q_pop;
  queue_head_t q_head;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SWING_MODE:       cfg_nxt.swing_mode       = cfg_wdata[0];
        CFG_DISCHARGE_KICK:   cfg_nxt.discharge_kick   = cfg_wdata[LEVEL_W-1:0];
        CFG_DISCHARGE_SNARE:  cfg_nxt.discharge_snare  = cfg_wdata[LEVEL_W-1:0];
        CFG_DELTA_KICK:       cfg_nxt.delta_kick       = cfg_wdata[LEVEL_W-1:0];
        CFG_DELTA_SNARE:      cfg_nxt.delta_snare      = cfg_wdata[LEVEL_W-1:0];
        CFG_REFRACTORY_KICK:  cfg_nxt.refractory_kick  = cfg_wdata[REFR_W-1:0];
        CFG_REFRACTORY_SNARE: cfg_nxt.refractory_snare = cfg_wdata[REFR_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swing_mode       <= 1'b0;
      cfg_r.discharge_kick   <= RST_DISCHARGE;
      cfg_r.discharge_snare  <= RST_DISCHARGE;
      cfg_r.delta_kick       <= RST_DELTA_KICK;
      cfg_r.delta_snare      <= RST_DELTA_SNARE;
      cfg_r.refractory_kick  <= RST_REFRACTORY;
      cfg_r.refractory_snare <= RST_REFRACTORY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dpod_front u_front (
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_now_ms       (in_now_ms),
    .in_tatum_period (in_tatum_period),
    .in_level_kick   (in_level_kick),
    .in_level_snare  (in_level_snare),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  dpod_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  dpod_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_onset_found    (out_onset_found),
    .out_onset_is_snare (out_onset_is_snare),
    .out_newest_slot    (out_newest_slot),
    .out_oldest_slot    (out_oldest_slot)
  );

endmodule
